### hdl/column_to_span_former_top_macros.svh
// Assertion helpers for the column to span former
`ifndef COLUMN_TO_SPAN_FORMER_TOP_MACROS_SVH
`define COLUMN_TO_SPAN_FORMER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define CSF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("column_to_span_former: check failed");

// Next-cycle implication
`define CSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("column_to_span_former: check failed");

`endif

### hdl/csf_pkg.sv
`default_nettype none
package csf_pkg;

    localparam int ROW_W = 6;        // row field width
    localparam int COLX_W = 10;      // column_x field width
    localparam int SPANX_W = 9;      // span x field width
    localparam int ROWS_DEF = 64;    // default store depth
    localparam int S_TDATA_W = 24;   // 10 + 6 + 6, padded to bytes
    localparam int M_TDATA_W = 24;   // 6 + 9 + 9
    localparam int Q_DEPTH = 2;      // command queue entries
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one run of rows: up for close-top/open-top, down for the bottom runs
    typedef struct packed {
        logic             vld;
        logic [ROW_W-1:0] start;
        logic [ROW_W-1:0] stop;
        logic [ROW_W-1:0] addr;   // store address of start
    } rng_t;

    // classified column: close-top, close-bottom, open-top, open-bottom
    typedef struct packed {
        rng_t [3:0]         rng;
        logic [SPANX_W-1:0] x_start;
        logic [SPANX_W-1:0] x_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // row modulo store depth, depth between 8 and 64
    function automatic logic [ROW_W-1:0] row_mod(input logic [ROW_W-1:0] row,
                                                 input int rows);
        logic [ROW_W:0] r;
        logic [ROW_W:0] d;
        r = {1'b0, row};
        d = (ROW_W+1)'(rows);
        for (int i = 0; i < 7; i++) begin
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[ROW_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/csf_front.sv
`default_nettype none
module csf_front #(
    parameter int ROWS = csf_pkg::ROWS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [csf_pkg::COLX_W-1:0]  column_x,
    input  wire logic [csf_pkg::ROW_W-1:0]   top_row,
    input  wire logic [csf_pkg::ROW_W-1:0]   bottom_row,
    input  wire csf_pkg::q_stat_t            q_stat,
    output logic                             q_push,
    output csf_pkg::cmd_t                    q_cmd
);

    localparam int W = csf_pkg::ROW_W;

    logic [W-1:0] prev_top_reg, prev_top_next;
    logic [W-1:0] prev_bot_reg, prev_bot_next;

    logic [W:0] t1, b1, t2, b2;
    logic [W:0] ct_hi, t1n, cb_lo, b1n, ot_hi, t2n, ob_lo;
    logic       ct_v, cb_v, ot_v, ob_v;

    assign in_ready = !q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    // classify: closed rows first (top up, bottom down), then newly covered rows
    always_comb begin
        t1 = {1'b0, prev_top_reg};
        b1 = {1'b0, prev_bot_reg};
        t2 = {1'b0, top_row};
        b2 = {1'b0, bottom_row};

        ct_v  = (t1 < t2) && (t1 <= b1);
        ct_hi = ((t2 - 1'b1) < b1) ? (t2 - 1'b1) : b1;
        t1n   = ct_v ? ct_hi + 1'b1 : t1;

        cb_v  = (b1 > b2) && (b1 >= t1n);
        cb_lo = ((b2 + 1'b1) > t1n) ? (b2 + 1'b1) : t1n;
        b1n   = cb_v ? cb_lo - 1'b1 : b1;

        ot_v  = (t2 < t1n) && (t2 <= b2);
        ot_hi = ((t1n - 1'b1) < b2) ? (t1n - 1'b1) : b2;
        t2n   = ot_v ? ot_hi + 1'b1 : t2;

        ob_v  = (b2 > b1n) && (b2 >= t2n);
        ob_lo = ((b1n + 1'b1) > t2n) ? (b1n + 1'b1) : t2n;

        q_cmd.rng[0] = '{vld: ct_v, start: t1[W-1:0], stop: ct_hi[W-1:0],
                         addr: csf_pkg::row_mod(t1[W-1:0], ROWS)};
        q_cmd.rng[1] = '{vld: cb_v, start: b1[W-1:0], stop: cb_lo[W-1:0],
                         addr: csf_pkg::row_mod(b1[W-1:0], ROWS)};
        q_cmd.rng[2] = '{vld: ot_v, start: t2[W-1:0], stop: ot_hi[W-1:0],
                         addr: csf_pkg::row_mod(t2[W-1:0], ROWS)};
        q_cmd.rng[3] = '{vld: ob_v, start: b2[W-1:0], stop: ob_lo[W-1:0],
                         addr: csf_pkg::row_mod(b2[W-1:0], ROWS)};
        q_cmd.x_start = column_x[csf_pkg::SPANX_W-1:0];
        q_cmd.x_last  = column_x[csf_pkg::SPANX_W-1:0] - 1'b1;
    end

    // previous column range follows every accepted item
    always_comb begin
        prev_top_next = q_push ? top_row : prev_top_reg;
        prev_bot_next = q_push ? bottom_row : prev_bot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_top_reg <= W'(63);
            prev_bot_reg <= '0;
        end else begin
            prev_top_reg <= prev_top_next;
            prev_bot_reg <= prev_bot_next;
        end
    end

endmodule
`default_nettype wire

### hdl/csf_queue.sv
`default_nettype none
module csf_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire csf_pkg::cmd_t    push_cmd,
    input  wire logic             pop,
    output csf_pkg::cmd_t         pop_cmd,
    output csf_pkg::q_stat_t      stat
);

    localparam int PW = csf_pkg::Q_PTR_W;
    localparam int CW = csf_pkg::Q_CNT_W;

    csf_pkg::cmd_t  ent_reg [csf_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CW'(csf_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = ent_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### hdl/csf_back.sv
`default_nettype none
module csf_back #(
    parameter int ROWS = csf_pkg::ROWS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire csf_pkg::q_stat_t             q_stat,
    input  wire csf_pkg::cmd_t                q_cmd,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [csf_pkg::ROW_W-1:0]         span_row,
    output logic [csf_pkg::SPANX_W-1:0]       span_first_x,
    output logic [csf_pkg::SPANX_W-1:0]       span_last_x,
    output logic                              last_span
);

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int W  = csf_pkg::ROW_W;
    localparam int XW = csf_pkg::SPANX_W;

    // phase codes, in execution order
    localparam logic [1:0] PH_CT = 2'd0;  // close top rows, ascending
    localparam logic [1:0] PH_CB = 2'd1;  // close bottom rows, descending
    localparam logic [1:0] PH_OT = 2'd2;  // open top rows, ascending
    localparam logic [1:0] PH_OB = 2'd3;  // open bottom rows, descending

    localparam int OF_DEPTH = 2;

    csf_pkg::cmd_t  cmd_reg;
    logic           busy_reg, busy_next;
    logic [1:0]     ph_reg, ph_next;
    logic [W-1:0]   row_reg;
    logic [AW-1:0]  addr_reg;

    logic [XW-1:0]  mem [ROWS];

    // output buffer, two items
    logic [W-1:0]   of_row_reg   [OF_DEPTH];
    logic [XW-1:0]  of_first_reg [OF_DEPTH];
    logic [XW-1:0]  of_lastx_reg [OF_DEPTH];
    logic           of_last_reg  [OF_DEPTH];
    logic           of_wr_reg, of_rd_reg;
    logic [1:0]     of_cnt_reg, of_cnt_next;

    csf_pkg::rng_t  cur, nxt;
    logic           is_emit, at_end, room, op_do, advance, emit_do, rec_do;
    logic           last_flag, of_pop;
    logic [AW-1:0]  addr_up, addr_dn;

    // step control for the current run
    always_comb begin
        cur       = cmd_reg.rng[ph_reg];
        nxt       = cmd_reg.rng[ph_reg + 2'd1];
        is_emit   = (ph_reg == PH_CT) || (ph_reg == PH_CB);
        at_end    = (row_reg == cur.stop);
        of_pop    = out_valid && out_ready;
        room      = (of_cnt_reg != 2'(OF_DEPTH)) || of_pop;
        op_do     = busy_reg && cur.vld && (!is_emit || room);
        advance   = busy_reg && (!cur.vld || (op_do && at_end));
        emit_do   = op_do && is_emit;
        rec_do    = op_do && !is_emit;
        last_flag = at_end && ((ph_reg == PH_CB) || !cmd_reg.rng[PH_CB].vld);
        q_pop     = !busy_reg && !q_stat.empty;
        addr_up   = (addr_reg == AW'(ROWS - 1)) ? '0 : addr_reg + 1'b1;
        addr_dn   = (addr_reg == '0) ? AW'(ROWS - 1) : addr_reg - 1'b1;
    end

    // sequencer
    always_comb begin
        busy_next = busy_reg;
        ph_next   = ph_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            ph_next   = PH_CT;
        end else if (advance) begin
            case (ph_reg)
                PH_OB:   busy_next = 1'b0;
                default: ph_next   = ph_reg + 2'd1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_CT;
        end else begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
        end
    end

    // run position and store address
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg  <= q_cmd;
            row_reg  <= q_cmd.rng[PH_CT].start;
            addr_reg <= q_cmd.rng[PH_CT].addr[AW-1:0];
        end else if (advance) begin
            row_reg  <= nxt.start;
            addr_reg <= nxt.addr[AW-1:0];
        end else if (op_do) begin
            row_reg  <= ph_reg[0] ? row_reg - 1'b1 : row_reg + 1'b1;
            addr_reg <= ph_reg[0] ? addr_dn : addr_up;
        end
    end

    // span start store; emit reads straight into the output buffer
    always_ff @(posedge aclk) begin
        if (rec_do) begin
            mem[addr_reg] <= cmd_reg.x_start;
        end
        if (emit_do) begin
            of_first_reg[of_wr_reg] <= mem[addr_reg];
            of_row_reg[of_wr_reg]   <= row_reg;
            of_lastx_reg[of_wr_reg] <= cmd_reg.x_last;
            of_last_reg[of_wr_reg]  <= last_flag;
        end
    end

    // output buffer bookkeeping
    always_comb begin
        of_cnt_next = of_cnt_reg + 2'(emit_do) - 2'(of_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            of_wr_reg  <= 1'b0;
            of_rd_reg  <= 1'b0;
            of_cnt_reg <= '0;
        end else begin
            of_wr_reg  <= of_wr_reg ^ emit_do;
            of_rd_reg  <= of_rd_reg ^ of_pop;
            of_cnt_reg <= of_cnt_next;
        end
    end

    assign out_valid    = (of_cnt_reg != '0);
    assign span_row     = of_row_reg[of_rd_reg];
    assign span_first_x = of_first_reg[of_rd_reg];
    assign span_last_x  = of_lastx_reg[of_rd_reg];
    assign last_span    = of_last_reg[of_rd_reg];

endmodule
`default_nettype wire

### hdl/column_to_span_former_top.sv
// Column to span former.
// Input stream (s_axis_*): one screen column per item, tdata holds column_x,
// top_row and bottom_row. An empty column (top_row > bottom_row) at maxx+1
// ends a plane and closes every open span.
// Output stream (m_axis_*): one item per closed row, tdata holds span_row,
// span_first_x and span_last_x; tlast marks the final span of a column.
// A front stage classifies each column into four row runs (close top, close
// bottom, open top, open bottom) and pushes it into a two-entry queue; the
// back sequencer walks the runs one row per cycle against the span start store,
// holding on a close while the output buffer is full. It loads a column from
// the queue, then takes each run in turn row by row; an empty run is stepped
// over on its own. With the back idle, the first span is valid once a column
// has passed the queue, been loaded and had its first close written into the
// output buffer, after the empty close-top run when only bottom rows close.
// Input is taken while the queue has room, so up to two columns wait behind
// the one being worked on.
// Reset clears the queue, the output buffer and the previous range (empty).
// Start store contents are undefined until a column opens a row.
// When m_axis_tready is low, spans wait in a two-item output buffer and the
// sequencer pauses on a close once the buffer is full; opens continue meanwhile.
`default_nettype none
`include "column_to_span_former_top_macros.svh"
module column_to_span_former_top #(
    parameter int ROWS = csf_pkg::ROWS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] column_x, [15:10] top_row, [21:16] bottom_row, [23:22] zero
    input  wire logic [csf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [5:0] span_row, [14:6] span_first_x, [23:15] span_last_x
    output logic [csf_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast
);

    csf_pkg::q_stat_t  q_stat;
    csf_pkg::cmd_t     push_cmd, pop_cmd;
    logic              q_push, q_pop;

    logic [csf_pkg::ROW_W-1:0]   span_row;
    logic [csf_pkg::SPANX_W-1:0] span_first_x, span_last_x;

    csf_front #(.ROWS(ROWS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .column_x   (s_axis_tdata[9:0]),
        .top_row    (s_axis_tdata[15:10]),
        .bottom_row (s_axis_tdata[21:16]),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    csf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    csf_back #(.ROWS(ROWS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .span_row     (span_row),
        .span_first_x (span_first_x),
        .span_last_x  (span_last_x),
        .last_span    (m_axis_tlast)
    );

    assign m_axis_tdata = {span_last_x, span_first_x, span_row};

    // queue never pushed when full nor popped when empty
    `CSF_ASSERT_IMPL(a_q_no_overflow, q_push, !q_stat.full)
    `CSF_ASSERT_IMPL(a_q_no_underflow, q_pop, !q_stat.empty)
    // a column is not taken while nothing can hold it
    `CSF_ASSERT_IMPL(a_ready_room, s_axis_tready, !q_stat.full)
    // output buffer starts empty when reset is released
    `CSF_ASSERT_IMPL(a_out_clear, $rose(aresetn), !m_axis_tvalid)

endmodule
`default_nettype wire
